FILE: hdl/assert_macros.svh
// Assertion macros shared by the checker files.
// No dependencies; every macro samples on clk and is disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every sampled edge.
`define RSC_ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("rsc assertion failed: invariant");

// If ante holds at one edge, cons must hold at the next edge.
`define RSC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rsc assertion failed: next-cycle rule");

`endif

FILE: hdl/rsc_pkg.sv
// Shared types and constants for the scissor clip block.
// No dependencies.
package rsc_pkg;

	localparam int CW         = 16;         // coordinate / texture width
	localparam int CFG_IDX_W  = 3;          // register index width (writes beyond 3 ignored)
	localparam int DIV_STAGES = 16;         // one quotient bit per stage
	localparam int NUM_W      = 2*CW + 2;   // 2*span*moved + extent
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SC_LEFT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SC_TOP    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SC_RIGHT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SC_BOTTOM = 3'd3;

	typedef struct packed {
		logic signed [CW-1:0] dst_left;
		logic signed [CW-1:0] dst_top;
		logic signed [CW-1:0] dst_right;
		logic signed [CW-1:0] dst_bottom;
		logic [CW-1:0]        tex_u0;
		logic [CW-1:0]        tex_v0;
		logic [CW-1:0]        tex_u1;
		logic [CW-1:0]        tex_v1;
		logic [CW-1:0]        instance_tag;
	} in_item_t;

	typedef struct packed {
		logic signed [CW-1:0] out_left;
		logic signed [CW-1:0] out_top;
		logic signed [CW-1:0] out_right;
		logic signed [CW-1:0] out_bottom;
		logic [CW-1:0]        out_u0;
		logic [CW-1:0]        out_v0;
		logic [CW-1:0]        out_u1;
		logic [CW-1:0]        out_v1;
		logic [CW-1:0]        out_tag;
	} out_item_t;

	// Fields that ride alongside the dividers.
	typedef struct packed {
		logic [CW-1:0] cl;
		logic [CW-1:0] ct;
		logic [CW-1:0] cr;
		logic [CW-1:0] cb;
		logic [CW-1:0] u0;
		logic [CW-1:0] v0;
		logic [CW-1:0] u1;
		logic [CW-1:0] v1;
		logic [CW-1:0] tag;
		logic          neg_u;
		logic          neg_v;
	} side_t;

	// Classified item from front to back.
	typedef struct packed {
		side_t         side;
		logic [CW-1:0] mag_u;
		logic [CW-1:0] mag_v;
		logic [CW-1:0] mv_l;
		logic [CW-1:0] mv_t;
		logic [CW-1:0] mv_r;
		logic [CW-1:0] mv_b;
		logic [CW-1:0] w;
		logic [CW-1:0] h;
	} work_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic full;
		logic empty;
	} fifo_ctl_t;

endpackage

FILE: hdl/rect_scissor_clip_uv.sv
// Path: an accepted input passes through the queue, the divider stages and the output register.
// Throughput: one rectangle per cycle; the divider lanes are fully pipelined,
// so only output backpressure (and a full queue behind it) stalls the input.
// Reset: arst_n asynchronous, active low; scissor resets to the full range,
// queue and pipeline valids clear; configuration is accepted every cycle.
// Depends on rsc_pkg, rsc_front, rsc_fifo, rsc_back.
module rect_scissor_clip_uv (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rsc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rsc_pkg::CW-1:0]        cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  rsc_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output rsc_pkg::out_item_t            out_data
);
	// Front: clip each edge against the scissor and decide cull. Culled
	// transactions are accepted and dropped; survivors enter the queue.
	logic               keep;
	rsc_pkg::work_t     wk_in, wk_out;
	rsc_pkg::fifo_ctl_t f_req, f_st;
	logic               take;

	assign cfg_ready = 1'b1;

	rsc_front u_front (
		.clk, .arst_n,
		.cfg_valid(cfg_valid), .cfg_index, .cfg_data,
		.item(in_data), .keep, .work(wk_in)
	);

	// Only stall the input when the queue is full.
	assign in_ready   = !f_st.full;
	assign f_req.push = in_valid && keep;
	assign f_req.pop  = take;
	assign f_req.full  = 1'b0;
	assign f_req.empty = 1'b0;

	rsc_fifo u_fifo (
		.clk, .arst_n,
		.ctl_in(f_req), .ctl_out(f_st),
		.wdata(wk_in), .rdata(wk_out)
	);

	// Back: the whole divider pipeline advances together whenever the
	// output register is free or being drained; bubbles carry no valid.
	rsc_back u_back (
		.clk, .arst_n,
		.avail(!f_st.empty), .work(wk_out), .take,
		.out_valid, .out_ready, .out_data
	);
endmodule

FILE: hdl/rsc_front.sv
// Front end: scissor registers, edge clipping, cull test, divider operands.
// Depends on rsc_pkg.
module rsc_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic [rsc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rsc_pkg::CW-1:0]            cfg_data,
	input  rsc_pkg::in_item_t                 item,
	output logic                              keep,
	output rsc_pkg::work_t                    work
);
	logic signed [rsc_pkg::CW-1:0] sc_l_q, sc_t_q, sc_r_q, sc_b_q;
	logic signed [rsc_pkg::CW-1:0] cl, ct, cr, cb;
	logic signed [rsc_pkg::CW:0]   cw, ch, su, sv, w, h, ml, mt, mr, mb;
	logic                          clip_l, clip_t, clip_r, clip_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_l_q <= 16'sh8000;
			sc_t_q <= 16'sh8000;
			sc_r_q <= 16'sh7fff;
			sc_b_q <= 16'sh7fff;
		end else if (cfg_valid) begin
			case (cfg_index)
				rsc_pkg::REG_SC_LEFT:   sc_l_q <= cfg_data;
				rsc_pkg::REG_SC_TOP:    sc_t_q <= cfg_data;
				rsc_pkg::REG_SC_RIGHT:  sc_r_q <= cfg_data;
				rsc_pkg::REG_SC_BOTTOM: sc_b_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		clip_l = item.dst_left < sc_l_q;
		clip_t = item.dst_top < sc_t_q;
		clip_r = item.dst_right > sc_r_q;
		clip_b = item.dst_bottom > sc_b_q;
		cl = clip_l ? sc_l_q : item.dst_left;
		ct = clip_t ? sc_t_q : item.dst_top;
		cr = clip_r ? sc_r_q : item.dst_right;
		cb = clip_b ? sc_b_q : item.dst_bottom;
		cw = 17'(cr) - 17'(cl);
		ch = 17'(cb) - 17'(ct);
		keep = (cw > 0) && (ch > 0);
		// surviving rect: original extents are in 1..65535, moves below them
		w  = 17'(item.dst_right) - 17'(item.dst_left);
		h  = 17'(item.dst_bottom) - 17'(item.dst_top);
		su = $signed({1'b0, item.tex_u1}) - $signed({1'b0, item.tex_u0});
		sv = $signed({1'b0, item.tex_v1}) - $signed({1'b0, item.tex_v0});
		ml = clip_l ? 17'(sc_l_q) - 17'(item.dst_left) : '0;
		mt = clip_t ? 17'(sc_t_q) - 17'(item.dst_top) : '0;
		mr = clip_r ? 17'(item.dst_right) - 17'(sc_r_q) : '0;
		mb = clip_b ? 17'(item.dst_bottom) - 17'(sc_b_q) : '0;

		work.side.cl    = cl;
		work.side.ct    = ct;
		work.side.cr    = cr;
		work.side.cb    = cb;
		work.side.u0    = item.tex_u0;
		work.side.v0    = item.tex_v0;
		work.side.u1    = item.tex_u1;
		work.side.v1    = item.tex_v1;
		work.side.tag   = item.instance_tag;
		work.side.neg_u = su[rsc_pkg::CW];
		work.side.neg_v = sv[rsc_pkg::CW];
		work.mag_u = su[rsc_pkg::CW] ? 16'(-su) : su[rsc_pkg::CW-1:0];
		work.mag_v = sv[rsc_pkg::CW] ? 16'(-sv) : sv[rsc_pkg::CW-1:0];
		work.mv_l  = ml[rsc_pkg::CW-1:0];
		work.mv_t  = mt[rsc_pkg::CW-1:0];
		work.mv_r  = mr[rsc_pkg::CW-1:0];
		work.mv_b  = mb[rsc_pkg::CW-1:0];
		work.w     = w[rsc_pkg::CW-1:0];
		work.h     = h[rsc_pkg::CW-1:0];
	end
endmodule

FILE: hdl/rsc_fifo.sv
// Short queue decoupling the front end from the divider pipeline.
// Depends on rsc_pkg.
module rsc_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  rsc_pkg::fifo_ctl_t ctl_in,
	output rsc_pkg::fifo_ctl_t ctl_out,
	input  rsc_pkg::work_t    wdata,
	output rsc_pkg::work_t    rdata
);
	rsc_pkg::work_t                mem_q [rsc_pkg::FIFO_DEPTH];
	logic [rsc_pkg::FIFO_AW-1:0]   wp_q, rp_q;
	logic [rsc_pkg::FIFO_AW:0]     cnt_q;
	logic                          do_push, do_pop;

	assign ctl_out.full  = cnt_q == (rsc_pkg::FIFO_AW+1)'(rsc_pkg::FIFO_DEPTH);
	assign ctl_out.empty = cnt_q == '0;
	assign ctl_out.push  = do_push;
	assign ctl_out.pop   = do_pop;
	assign do_push = ctl_in.push && !ctl_out.full;
	assign do_pop  = ctl_in.pop && !ctl_out.empty;
	assign rdata   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wp_q <= wp_q + 1'b1;
			if (do_pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (rsc_pkg::FIFO_AW+1)'(do_push) - (rsc_pkg::FIFO_AW+1)'(do_pop);
		end
	end
endmodule

FILE: hdl/rsc_div.sv
// Pipelined rounded divider: q = round(mag*moved/den), one quotient bit a stage.
// Depends on rsc_pkg. The pipeline advances only while en is high.
module rsc_div (
	input  logic                   clk,
	input  logic                   en,
	input  logic [rsc_pkg::CW-1:0] mag,
	input  logic [rsc_pkg::CW-1:0] moved,
	input  logic [rsc_pkg::CW-1:0] den,
	output logic [rsc_pkg::CW-1:0] q
);
	localparam int NS = rsc_pkg::DIV_STAGES;
	localparam int NW = rsc_pkg::NUM_W;

	logic [NW-1:0]          rem_q [NS+1];
	logic [rsc_pkg::CW:0]   dv_q  [NS+1];
	logic [rsc_pkg::CW-1:0] quo_q [NS+1];
	logic [2*rsc_pkg::CW-1:0] prod;

	assign prod = mag * moved;
	assign q    = quo_q[NS];

	// Numerator 2*prod+den over 2*den gives round half up; prod < mag*den keeps q < 2^16.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= {1'b0, prod, 1'b0} + NW'(den);
			dv_q[0]  <= {den, 1'b0};
			quo_q[0] <= '0;
			for (int k = 1; k <= NS; k++) begin
				logic [NW-1:0] sub;
				sub = NW'(dv_q[k-1]) << (NS - k);
				dv_q[k] <= dv_q[k-1];
				if (rem_q[k-1] >= sub) begin
					rem_q[k] <= rem_q[k-1] - sub;
					quo_q[k] <= quo_q[k-1] | (rsc_pkg::CW'(1) << (NS - k));
				end else begin
					rem_q[k] <= rem_q[k-1];
					quo_q[k] <= quo_q[k-1];
				end
			end
		end
	end
endmodule

FILE: hdl/rsc_back.sv
// Back end: four divider lanes, texture adjust with clamping, output register.
// Depends on rsc_pkg and rsc_div.
module rsc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               avail,
	input  rsc_pkg::work_t     work,
	output logic               take,
	output logic               out_valid,
	input  logic               out_ready,
	output rsc_pkg::out_item_t out_data
);
	localparam int NS = rsc_pkg::DIV_STAGES;

	rsc_pkg::side_t         side_q [NS+1];
	logic [NS:0]            vld_q;
	logic                   adv;
	logic [rsc_pkg::CW-1:0] q_l, q_t, q_r, q_b;
	rsc_pkg::side_t         s;
	rsc_pkg::out_item_t     res;

	assign adv  = !out_valid || out_ready;
	assign take = adv && avail;
	assign s    = side_q[NS];

	rsc_div u_div_l (.clk, .en(adv), .mag(work.mag_u), .moved(work.mv_l), .den(work.w), .q(q_l));
	rsc_div u_div_t (.clk, .en(adv), .mag(work.mag_v), .moved(work.mv_t), .den(work.h), .q(q_t));
	rsc_div u_div_r (.clk, .en(adv), .mag(work.mag_u), .moved(work.mv_r), .den(work.w), .q(q_r));
	rsc_div u_div_b (.clk, .en(adv), .mag(work.mag_v), .moved(work.mv_b), .den(work.h), .q(q_b));

	function automatic logic [rsc_pkg::CW-1:0] adj(input logic [rsc_pkg::CW-1:0] base,
			input logic [rsc_pkg::CW-1:0] amt, input logic sub);
		logic signed [rsc_pkg::CW+1:0] v;
		v = sub ? $signed({2'b00, base}) - $signed({2'b00, amt})
			: $signed({2'b00, base}) + $signed({2'b00, amt});
		if (v < 0) return '0;
		if (v[rsc_pkg::CW]) return '1;
		return v[rsc_pkg::CW-1:0];
	endfunction

	always_comb begin
		res.out_left   = s.cl;
		res.out_top    = s.ct;
		res.out_right  = s.cr;
		res.out_bottom = s.cb;
		res.out_u0     = adj(s.u0, q_l, s.neg_u);
		res.out_v0     = adj(s.v0, q_t, s.neg_v);
		res.out_u1     = adj(s.u1, q_r, !s.neg_u);
		res.out_v1     = adj(s.v1, q_b, !s.neg_v);
		res.out_tag    = s.tag;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_q[0] <= work.side;
			for (int k = 1; k <= NS; k++) side_q[k] <= side_q[k-1];
			out_data <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_valid <= 1'b0;
		end else if (adv) begin
			vld_q     <= {vld_q[NS-1:0], avail};
			out_valid <= vld_q[NS];
		end
	end
endmodule

FILE: hdl/rsc_checker.sv
// Port-level checker for the scissor clip block, bound to the top level.
// Depends on rsc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rsc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cfg_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input rsc_pkg::out_item_t            out_data
);
	`RSC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	`RSC_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data))
	`RSC_ASSERT_ALWAYS(a_cfg_ready, cfg_ready)
	`RSC_ASSERT_ALWAYS(a_nonempty, !out_valid || (out_data.out_left < out_data.out_right && out_data.out_top < out_data.out_bottom))
endmodule

bind rect_scissor_clip_uv rsc_checker u_rsc_checker (.*);
